@@ sv/ppd_pkg.sv @@
// ----------------------------------------------------------------------------
// Poll packet event decoder package
// Shared types, codes and sizing constants for the poll packet event decoder.
// ----------------------------------------------------------------------------
package ppd_pkg;

	// Protocol bytes and packet limits.
	localparam logic [7:0] POLL_BYTE = 8'h5a;
	localparam logic [7:0] ACK_BYTE  = 8'hc3;
	localparam logic [7:0] MAX_LEN   = 8'd9;

	// Address queue sizing.
	localparam int ADDR_DEPTH = 8;
	localparam int QIDX_W     = (ADDR_DEPTH > 1) ? $clog2(ADDR_DEPTH) : 1;
	localparam int COUNT_W    = 4;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_SEND  = 2'd0,
		KIND_ADDR  = 2'd1,
		KIND_FUNC  = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	// Error codes.
	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_CLAMPED  = 2'd1,
		ERR_OVERFLOW = 2'd2,
		ERR_SPARE    = 2'd3
	} err_t;

	// Packet receive phase.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LEN  = 2'd1,
		PH_MASK = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	// Result sequencer states.
	typedef enum logic [1:0] {
		SQ_IDLE = 2'd0,
		SQ_READ = 2'd1,
		SQ_ADDR = 2'd2,
		SQ_FUNC = 2'd3
	} seq_state_t;

	// Write request into the address queue.
	typedef struct packed {
		logic              en;
		logic [QIDX_W-1:0] idx;
		logic [7:0]        data;
	} q_wr_t;

	// Read request into the address queue.
	typedef struct packed {
		logic              en;
		logic [QIDX_W-1:0] idx;
	} q_rd_t;

endpackage

@@ sv/ppd_queue.sv @@
// ----------------------------------------------------------------------------
// Address queue storage
// Small memory holding queued house and unit nibbles, with a registered read.
// ----------------------------------------------------------------------------
module ppd_queue (
	input  logic          clk,
	input  ppd_pkg::q_wr_t wr,
	input  ppd_pkg::q_rd_t rd,
	output logic [7:0]    rd_data
);
	import ppd_pkg::*;

	logic [7:0] mem_q [ADDR_DEPTH];
	logic [7:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.idx] <= wr.data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_q <= mem_q[rd.idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/poll_packet_event_decoder_top.sv @@
// ----------------------------------------------------------------------------
// Poll packet event decoder
// Decodes poll packets from a powerline interface link into send, address,
// function and error results.
// ----------------------------------------------------------------------------
// A direct result (acknowledge, error or function with an empty queue) is
// presented in the cycle after its beat is accepted. A function byte with
// queued addresses takes one queue read and one output load per address,
// then the load of the function result itself.
// Reset clears the phase, counters, sequencer and output valid; queue
// contents are undefined until written.
module poll_packet_event_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] tx_byte,
	output logic [3:0] house_code,
	output logic [3:0] unit_code,
	output logic [3:0] command,
	output logic [1:0] error_code,
	output logic       last
);
	import ppd_pkg::*;

	seq_state_t         st_q, st_d;
	phase_t             phase_q;
	logic [3:0]         bytes_left_q;
	logic [7:0]         function_mask_q;
	logic [3:0]         data_index_q;
	logic [COUNT_W-1:0] queue_count_q;
	logic [COUNT_W-1:0] rd_idx_q;
	logic [3:0]         func_house_q;
	logic [3:0]         func_cmd_q;

	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] tx_byte_q;
	logic [3:0] house_q;
	logic [3:0] unit_q;
	logic [3:0] cmd_q;
	logic [1:0] err_q;
	logic       last_q;

	logic       in_acc;
	logic       out_free;
	logic       is_poll;
	logic       len_over;
	logic       mask_bit;
	logic       is_func;
	logic       is_addr;
	logic       q_full;
	logic       q_empty;
	logic       rd_final;
	logic [3:0] bytes_next;
	logic [7:0] rd_data;
	q_wr_t      q_wr;
	q_rd_t      q_rd;

	logic       out_load;
	kind_t      ld_kind;
	logic [7:0] ld_tx;
	logic [3:0] ld_house;
	logic [3:0] ld_unit;
	logic [3:0] ld_cmd;
	err_t       ld_err;
	logic       ld_last;

	// Handshake.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((st_q == SQ_IDLE) && out_free);
	assign in_acc   = in_valid && !in_stall;

	// Byte decode against the current phase.
	assign is_poll    = (phase_q == PH_IDLE) && (rx_byte == POLL_BYTE);
	assign len_over   = (phase_q == PH_LEN) && (rx_byte > MAX_LEN);
	assign mask_bit   = function_mask_q[data_index_q[2:0]];
	assign is_func    = (phase_q == PH_DATA) && mask_bit;
	assign is_addr    = (phase_q == PH_DATA) && !mask_bit;
	assign q_full     = (queue_count_q == COUNT_W'(ADDR_DEPTH));
	assign q_empty    = (queue_count_q == '0);
	assign rd_final   = ((rd_idx_q + COUNT_W'(1)) == queue_count_q);
	assign bytes_next = bytes_left_q - 4'd1;

	// Queue access.
	assign q_wr.en   = in_acc && is_addr && !q_full;
	assign q_wr.idx  = queue_count_q[QIDX_W-1:0];
	assign q_wr.data = rx_byte;
	assign q_rd.en   = (st_q == SQ_READ);
	assign q_rd.idx  = rd_idx_q[QIDX_W-1:0];

	ppd_queue u_queue (
		.clk     (clk),
		.wr      (q_wr),
		.rd      (q_rd),
		.rd_data (rd_data)
	);

	// Sequencer next state.
	always_comb begin
		st_d = st_q;
		case (st_q)
			SQ_IDLE: begin
				if (in_acc && is_func && !q_empty) begin
					st_d = SQ_READ;
				end
			end
			SQ_READ: begin
				st_d = SQ_ADDR;
			end
			SQ_ADDR: begin
				if (out_free) begin
					st_d = rd_final ? SQ_FUNC : SQ_READ;
				end
			end
			SQ_FUNC: begin
				if (out_free) begin
					st_d = SQ_IDLE;
				end
			end
			default: begin
				st_d = SQ_IDLE;
			end
		endcase
	end

	// Sequencer outputs: which result is loaded into the output register.
	always_comb begin
		out_load = 1'b0;
		ld_kind  = KIND_SEND;
		ld_tx    = '0;
		ld_house = '0;
		ld_unit  = '0;
		ld_cmd   = '0;
		ld_err   = ERR_NONE;
		ld_last  = 1'b1;
		case (st_q)
			SQ_IDLE: begin
				if (in_acc) begin
					if (is_poll) begin
						out_load = 1'b1;
						ld_tx    = ACK_BYTE;
					end else if (len_over) begin
						out_load = 1'b1;
						ld_kind  = KIND_ERROR;
						ld_err   = ERR_CLAMPED;
					end else if (is_func && q_empty) begin
						out_load = 1'b1;
						ld_kind  = KIND_FUNC;
						ld_house = rx_byte[7:4];
						ld_cmd   = rx_byte[3:0];
					end else if (is_addr && q_full) begin
						out_load = 1'b1;
						ld_kind  = KIND_ERROR;
						ld_err   = ERR_OVERFLOW;
					end
				end
			end
			SQ_ADDR: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_kind  = KIND_ADDR;
					ld_house = rd_data[7:4];
					ld_unit  = rd_data[3:0];
					ld_last  = 1'b0;
				end
			end
			SQ_FUNC: begin
				if (out_free) begin
					out_load = 1'b1;
					ld_kind  = KIND_FUNC;
					ld_house = func_house_q;
					ld_cmd   = func_cmd_q;
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SQ_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// Packet phase, counters and queue fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			bytes_left_q    <= '0;
			function_mask_q <= '0;
			data_index_q    <= '0;
			queue_count_q   <= '0;
			rd_idx_q        <= '0;
		end else begin
			if (in_acc) begin
				case (phase_q)
					PH_IDLE: begin
						if (is_poll) begin
							phase_q <= PH_LEN;
						end
					end
					PH_LEN: begin
						bytes_left_q <= len_over ? MAX_LEN[3:0] : rx_byte[3:0];
						phase_q      <= (rx_byte == 8'd0) ? PH_IDLE : PH_MASK;
					end
					PH_MASK: begin
						function_mask_q <= rx_byte;
						data_index_q    <= '0;
						bytes_left_q    <= bytes_next;
						phase_q         <= (bytes_next == 4'd0) ? PH_IDLE : PH_DATA;
					end
					PH_DATA: begin
						data_index_q <= data_index_q + 4'd1;
						bytes_left_q <= bytes_next;
						phase_q      <= (bytes_next == 4'd0) ? PH_IDLE : PH_DATA;
						if (is_addr && !q_full) begin
							queue_count_q <= queue_count_q + COUNT_W'(1);
						end
						if (is_func) begin
							rd_idx_q <= '0;
						end
					end
					default: begin
						phase_q <= PH_IDLE;
					end
				endcase
			end
			// Walk the queue, then empty it once the function is out.
			if ((st_q == SQ_ADDR) && out_free) begin
				rd_idx_q <= rd_idx_q + COUNT_W'(1);
			end
			if ((st_q == SQ_FUNC) && out_free) begin
				queue_count_q <= '0;
			end
		end
	end

	// Function byte held while the queued addresses go out.
	always_ff @(posedge clk) begin
		if (in_acc && is_func) begin
			func_house_q <= rx_byte[7:4];
			func_cmd_q   <= rx_byte[3:0];
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q    <= ld_kind;
			tx_byte_q <= ld_tx;
			house_q   <= ld_house;
			unit_q    <= ld_unit;
			cmd_q     <= ld_cmd;
			err_q     <= ld_err;
			last_q    <= ld_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign tx_byte    = tx_byte_q;
	assign house_code = house_q;
	assign unit_code  = unit_q;
	assign command    = cmd_q;
	assign error_code = err_q;
	assign last       = last_q;

endmodule

@@ tb/tb_poll_packet_event_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Poll packet event decoder testbench
// Feeds received bytes into the decoder with random gaps on the input side and
// random stalls on the output side. A scoreboard decodes the same bytes into
// the send, address, function and error beats that the block should produce
// and checks every output beat against them in order.
// ----------------------------------------------------------------------------
module tb_poll_packet_event_decoder_top;
	import ppd_pkg::*;

	// One output beat as the decoder presents it.
	typedef struct {
		kind_t      kind;
		logic [7:0] tx;
		logic [3:0] house;
		logic [3:0] unit;
		logic [3:0] cmd;
		err_t       err;
		logic       last;
	} decode_beat_t;

	class decoder_scoreboard;
		// Packet decoder state, kept in step with the block.
		phase_t     phase;
		logic [3:0] bytes_left;
		logic [7:0] func_mask;
		logic [3:0] data_idx;
		logic [7:0] addr_queue [ADDR_DEPTH];
		logic [3:0] queued;

		decode_beat_t pending_beats[$];
		int n_rx;
		int n_checked;
		int n_fail;
		int n_events;
		int n_overflows;

		function new();
			phase = PH_IDLE;
			bytes_left = '0;
			func_mask = '0;
			data_idx = '0;
			queued = '0;
		endfunction

		function void push_beat(kind_t k, logic [7:0] tx, logic [3:0] house,
				logic [3:0] unit, logic [3:0] cmd, err_t err, logic last);
			decode_beat_t b;
			b.kind = k;
			b.tx = tx;
			b.house = house;
			b.unit = unit;
			b.cmd = cmd;
			b.err = err;
			b.last = last;
			pending_beats.insert(pending_beats.size(), b);
		endfunction

		// Decodes one accepted byte into the beats it should cause.
		function void note_rx_byte(logic [7:0] b);
			n_rx++;
			case (phase)
				PH_IDLE: begin
					if (b == POLL_BYTE) begin
						push_beat(KIND_SEND, ACK_BYTE, 4'd0, 4'd0, 4'd0, ERR_NONE, 1'b1);
						phase = PH_LEN;
					end
				end
				PH_LEN: begin
					if (b > MAX_LEN) begin
						push_beat(KIND_ERROR, 8'd0, 4'd0, 4'd0, 4'd0, ERR_CLAMPED, 1'b1);
						bytes_left = MAX_LEN[3:0];
					end else begin
						bytes_left = b[3:0];
					end
					phase = (bytes_left == 4'd0) ? PH_IDLE : PH_MASK;
				end
				PH_MASK: begin
					func_mask = b;
					data_idx = 4'd0;
					bytes_left = bytes_left - 4'd1;
					phase = (bytes_left == 4'd0) ? PH_IDLE : PH_DATA;
				end
				default: begin
					if (func_mask[data_idx[2:0]]) begin
						// A function flushes the queued addresses ahead of itself.
						for (int i = 0; i < queued; i++)
							push_beat(KIND_ADDR, 8'd0, addr_queue[i][7:4],
								addr_queue[i][3:0], 4'd0, ERR_NONE, 1'b0);
						push_beat(KIND_FUNC, 8'd0, b[7:4], 4'd0, b[3:0], ERR_NONE, 1'b1);
						queued = 4'd0;
						n_events++;
					end else if (queued < ADDR_DEPTH) begin
						addr_queue[queued[QIDX_W-1:0]] = b;
						queued = queued + 4'd1;
					end else begin
						push_beat(KIND_ERROR, 8'd0, 4'd0, 4'd0, 4'd0, ERR_OVERFLOW, 1'b1);
						n_overflows++;
					end
					data_idx = data_idx + 4'd1;
					bytes_left = bytes_left - 4'd1;
					phase = (bytes_left == 4'd0) ? PH_IDLE : PH_DATA;
				end
			endcase
		endfunction

		function void compare_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
			if (got_val !== exp_val) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
				n_fail++;
			end
		endfunction

		// Checks one output beat against the oldest expected beat.
		function void check_result(decode_beat_t got);
			decode_beat_t exp_beat;
			if (pending_beats.size() == 0) begin
				$error("unexpected output beat: kind %0d", got.kind);
				n_fail++;
				return;
			end
			exp_beat = pending_beats.pop_front();
			n_checked++;
			compare_field("kind", 8'(exp_beat.kind), 8'(got.kind));
			compare_field("tx_byte", exp_beat.tx, got.tx);
			compare_field("house_code", 8'(exp_beat.house), 8'(got.house));
			compare_field("unit_code", 8'(exp_beat.unit), 8'(got.unit));
			compare_field("command", 8'(exp_beat.cmd), 8'(got.cmd));
			compare_field("error_code", 8'(exp_beat.err), 8'(got.err));
			compare_field("last", 8'(exp_beat.last), 8'(got.last));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] tx_byte;
	logic [3:0] house_code;
	logic [3:0] unit_code;
	logic [3:0] command;
	logic [1:0] error_code;
	logic       last;

	decoder_scoreboard sb;
	bit calm = 1'b0;
	int stall_left = 0;
	int n_packets = 0;
	int n_long = 0;

	poll_packet_event_decoder_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.tx_byte    (tx_byte),
		.house_code (house_code),
		.unit_code  (unit_code),
		.command    (command),
		.error_code (error_code),
		.last       (last)
	);

	always #4 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// Presents one byte after a random gap and holds it until accepted.
	task automatic send_beat(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_rx_byte(b);
	endtask

	// Either idle noise, or a poll packet with random length, mask and data.
	// Some packets are cut short so that the next bytes land in the data phase.
	task automatic send_random_packet();
		logic [7:0] len;
		int body;
		int n_data;
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)));
			return;
		end
		n_packets++;
		send_beat(POLL_BYTE);
		if ($urandom_range(0, 99) < 10) begin
			len = 8'($urandom_range(10, 255));
			n_long++;
		end else begin
			len = 8'($urandom_range(0, 9));
		end
		send_beat(len);
		body = int'((len > MAX_LEN) ? MAX_LEN : len);
		if (body == 0)
			return;
		send_beat(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
		n_data = body - 1;
		if ($urandom_range(0, 9) == 0)
			n_data = $urandom_range(0, n_data);
		repeat (n_data) send_beat(8'($urandom_range(0, 255)));
		// Bytes past a clamped length arrive while idle, unless the packet was cut short.
		if (len > MAX_LEN)
			repeat ($urandom_range(0, 3)) send_beat(8'($urandom_range(0, 255)));
	endtask

	// Output side: check accepted beats and stall at random.
	always @(posedge clk) begin
		decode_beat_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.kind = kind_t'(kind);
				got.tx = tx_byte;
				got.house = house_code;
				got.unit = unit_code;
				got.cmd = command;
				got.err = err_t'(error_code);
				got.last = last;
				sb.check_result(got);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = pick_gap();
			end
		end
	end

	// Directed bytes: empty packet, idle noise, mask-only packet, clamped
	// length that fills the queue, a dropped byte after it, an overflowing
	// address followed by a function that flushes the full queue, and a
	// function with an empty queue.
	logic [7:0] directed_bytes[$] = '{
		8'h5a, 8'h00,
		8'h00, 8'hff,
		8'h5a, 8'h01, 8'hff,
		8'h5a, 8'h0a, 8'h00, 8'h00, 8'hff, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc,
		8'ha5,
		8'h5a, 8'h03, 8'h02, 8'hde, 8'h3c,
		8'h5a, 8'h02, 8'h01, 8'hf0
	};

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i])
			send_beat(directed_bytes[i]);

		// Random packets, with a stretch in the middle that has no idling.
		while (sb.n_rx < 470) begin
			calm = (n_packets >= 60 && n_packets < 80);
			send_random_packet();
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (sb.pending_beats.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d bytes in %0d poll packets (%0d over length).",
			sb.n_rx, n_packets, n_long);
		$display("Checked %0d beats: %0d function events, %0d queue overflows.",
			sb.n_checked, sb.n_events, sb.n_overflows);
		if (sb.n_fail == 0)
			$display("tb_poll_packet_event_decoder_top OK");
		else
			$display("tb_poll_packet_event_decoder_top NOT OK");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#8ms;
		$display("tb_poll_packet_event_decoder_top NOT OK");
		$finish;
	end

endmodule

@@ poll_packet_event_decoder_top.f @@
sv/ppd_pkg.sv
sv/ppd_queue.sv
sv/poll_packet_event_decoder_top.sv
tb/tb_poll_packet_event_decoder_top.sv
